>>> rtl/uvsph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvsph_pkg
// constants and types shared by the uv sphere mesh point generator
// ----------------------------------------------------------------------------
package uvsph_pkg;

    localparam int MAX_SLICES  = 255;
    localparam int ANGLE_BITS  = 16;
    localparam int SLICE_RESET = 64;
    localparam int RADIUS_RESET = 256;

    // quarter-wave sine polynomial coefficients, Q30
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd688904866;
    localparam logic [26:0] POLY_C = 27'd76016977;

    // register indexes
    localparam logic REG_NUM_SLICES = 1'b0;
    localparam logic REG_RADIUS     = 1'b1;

    // number of register stages after the input stage
    localparam int PIPE_LAST = 10;

    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        quad_valid;
        logic [15:0] corner_a;
        logic [15:0] corner_b;
        logic [15:0] corner_c;
        logic [15:0] corner_f;
    } t_side;

endpackage : uvsph_pkg
`default_nettype wire

>>> rtl/uv_sphere_mesh_point_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_mesh_point_top
// position, texture coordinates and quad corner indices of one uv sphere point
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+--------------------------
//  point in | start, busy, i_ring_index, i_slice_index | start high, busy low
//  result   | o_valid, o_pos_*, o_tex_*, o_corner_*    | o_valid high (one cycle)
//  config   | psel, penable, pwrite, paddr, pwdata     | psel & penable & pwrite
//
//  one point per cycle while busy is low
//  the pipeline includes the four-stage sine polynomial and the two position products
//  after reset and after each num_slices write, busy is high while the serial divider
//  builds the 1/slices and 1/rings reciprocals
//  the receiver cannot stall; results leave on o_valid
// ----------------------------------------------------------------------------
module uv_sphere_mesh_point_top
    import uvsph_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [6:0]  i_ring_index,
    input  wire logic [7:0]  i_slice_index,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic             o_valid,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic [16:0]      o_tex_u,
    output logic [16:0]      o_tex_v,
    output logic             o_quad_valid,
    output logic [15:0]      o_corner_a,
    output logic [15:0]      o_corner_b,
    output logic [15:0]      o_corner_c,
    output logic [15:0]      o_corner_d,
    output logic [15:0]      o_corner_e,
    output logic [15:0]      o_corner_f
);

    // configuration
    logic [7:0]  r_num_slices;
    logic [15:0] r_radius;
    logic [7:0]  s_eff;
    logic [6:0]  r_eff;
    logic        cfg_wr;

    // reciprocal divider
    logic [5:0]  r_div_cnt;
    logic [7:0]  r_rem_s, r_rem_r;
    logic [31:0] r_q_s, r_q_r;
    logic [31:0] r_recip_s, r_recip_r;
    logic [8:0]  n_rem_s_sh, n_rem_r_sh;
    logic        n_qb_s, n_qb_r;
    logic [7:0]  n_rem_s, n_rem_r;

    // pipeline
    logic [PIPE_LAST:0] r_vld;
    logic        accept;
    logic [6:0]  r_a_i;
    logic [7:0]  r_a_j;
    logic [6:0]  n_i;
    logic [7:0]  n_j;

    logic [23:0] n_num_i, n_num_j, n_num_v;
    logic [55:0] r_b_pi, r_b_pj, r_b_pv;
    logic [16:0] n_k;
    logic        n_qv;
    logic        r_b_qv;
    logic [16:0] r_b_k;
    logic [8:0]  w;

    logic [15:0] ang_i, ang_j;
    logic [15:0] ang [4];
    logic [14:0] r_g [4];
    logic        r_qn [4];
    t_side       n_side;
    t_side       r_side [8];

    logic [30:0] r_z2  [4];
    logic [14:0] r_g1  [4];
    logic        r_qn1 [4];
    logic [56:0] r_t   [4];
    logic [30:0] r_z2b [4];
    logic [14:0] r_g2  [4];
    logic        r_qn2 [4];
    logic [59:0] r_u   [4];
    logic [14:0] r_g3  [4];
    logic        r_qn3 [4];
    logic [45:0] r_v   [4];
    logic        r_qn4 [4];
    logic [14:0] r_mag [4];
    logic        r_neg [4];

    logic [29:0] r_pxs, r_pzs;
    logic [30:0] r_py;
    logic        r_nx1, r_nz1, r_ny1;
    logic [45:0] r_px, r_pz;
    logic [16:0] r_ymag;
    logic        r_nx2, r_nz2, r_ny2;

    assign s_eff  = (r_num_slices < 8'd2) ? 8'd2 : r_num_slices;
    assign r_eff  = s_eff[7:1];
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = (r_div_cnt != 6'd0);
    assign accept = start && !busy;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_NUM_SLICES: prdata = {24'd0, r_num_slices};
            REG_RADIUS:     prdata = {16'd0, r_radius};
            default:        prdata = 32'd0;
        endcase
    end

    // restoring division of (2^32 - 1) by S and of (2^31 - 1) by R, one bit a cycle while no register write is taken
    always_comb begin
        n_rem_s_sh = {r_rem_s, 1'b1};
        n_rem_r_sh = {r_rem_r, (r_div_cnt != 6'd32)};
        n_qb_s = (n_rem_s_sh >= {1'b0, s_eff});
        n_qb_r = (n_rem_r_sh >= {2'b0, r_eff});
        n_rem_s = n_qb_s ? 8'(n_rem_s_sh - {1'b0, s_eff}) : n_rem_s_sh[7:0];
        n_rem_r = n_qb_r ? 8'(n_rem_r_sh - {2'b0, r_eff}) : n_rem_r_sh[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slices <= 8'(SLICE_RESET);
            r_radius     <= 16'(RADIUS_RESET);
            r_div_cnt    <= 6'd32;
            r_rem_s      <= 8'd0;
            r_rem_r      <= 8'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_NUM_SLICES: begin
                    r_num_slices <= pwdata[7:0];
                    r_div_cnt    <= 6'd32;
                    r_rem_s      <= 8'd0;
                    r_rem_r      <= 8'd0;
                end
                REG_RADIUS: r_radius <= pwdata[15:0];
                default: ;
            endcase
        end else if (busy) begin
            r_div_cnt <= r_div_cnt - 6'd1;
            r_rem_s   <= n_rem_s;
            r_rem_r   <= n_rem_r;
            r_q_s     <= {r_q_s[30:0], n_qb_s};
            r_q_r     <= {r_q_r[30:0], n_qb_r};
            if (r_div_cnt == 6'd1) begin
                r_recip_s <= {r_q_s[30:0], n_qb_s} + 32'd1;
                r_recip_r <= {r_q_r[30:0], n_qb_r} + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAST-1:0], accept};
        end
    end

    // stage a: clamp the indexes
    assign n_i = ({1'b0, i_ring_index} > {1'b0, r_eff}) ? r_eff : i_ring_index;
    assign n_j = (i_slice_index > s_eff) ? s_eff : i_slice_index;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_i <= n_i;
            r_a_j <= n_j;
        end
    end

    // stage b: quotients by reciprocal multiplication, vertex index
    assign w       = {1'b0, s_eff} + 9'd1;
    assign n_num_i = {1'b0, r_a_i, 16'd0} + {17'd0, r_eff};
    assign n_num_j = {r_a_j, 16'd0} + {17'd0, r_eff};
    assign n_num_v = {1'b0, r_a_i, 16'd0} + {18'd0, r_eff[6:1]};
    assign n_k     = ({10'd0, r_a_i} * {8'd0, w}) + {9'd0, r_a_j};
    assign n_qv    = (r_a_i < r_eff) && (r_a_j < s_eff);

    always_ff @(posedge i_clk) begin
        r_b_pi <= n_num_i * r_recip_s;
        r_b_pj <= n_num_j * r_recip_s;
        r_b_pv <= n_num_v * r_recip_r;
        r_b_k  <= n_k;
        r_b_qv <= n_qv;
    end

    // stage c: angles, quadrant fold, texture coordinates, corners
    assign ang_i  = r_b_pi[47:32];
    assign ang_j  = r_b_pj[47:32];
    assign ang[0] = ang_i;
    assign ang[1] = ang_i + 16'd16384;
    assign ang[2] = ang_j;
    assign ang[3] = ang_j + 16'd16384;

    always_comb begin
        n_side.tex_u      = r_b_pj[48:32];
        n_side.tex_v      = 17'd65536 - r_b_pv[47:31];
        n_side.quad_valid = r_b_qv;
        n_side.corner_a   = r_b_qv ? r_b_k[15:0] : 16'd0;
        n_side.corner_b   = r_b_qv ? 16'(r_b_k + {8'd0, w}) : 16'd0;
        n_side.corner_c   = r_b_qv ? 16'(r_b_k + {8'd0, w} + 17'd1) : 16'd0;
        n_side.corner_f   = r_b_qv ? 16'(r_b_k + 17'd1) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_g[l]  <= ang[l][14] ? 15'(15'd16384 - {1'b0, ang[l][13:0]})
                                  : {1'b0, ang[l][13:0]};
            r_qn[l] <= ang[l][15];
        end
        r_side[0] <= n_side;
        for (int d = 1; d < 8; d++) begin
            r_side[d] <= r_side[d-1];
        end
    end

    // sine polynomial, four lanes: sin i, cos i, sin j, cos j
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            r_z2[l]  <= {{14'd0, r_g[l]} * {14'd0, r_g[l]}, 2'b00};
            r_g1[l]  <= r_g[l];
            r_qn1[l] <= r_qn[l];

            r_t[l]   <= POLY_C * r_z2[l];
            r_z2b[l] <= r_z2[l];
            r_g2[l]  <= r_g1[l];
            r_qn2[l] <= r_qn1[l];

            r_u[l]   <= 30'(POLY_B - r_t[l][56:30]) * r_z2b[l];
            r_g3[l]  <= r_g2[l];
            r_qn3[l] <= r_qn2[l];

            r_v[l]   <= r_g3[l] * 31'(POLY_A - r_u[l][59:30]);
            r_qn4[l] <= r_qn3[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 4; l++) begin
            logic [17:0] mag;
            mag = 18'((r_v[l] + 46'd268435456) >> 29);
            r_mag[l] <= (mag > 18'd32767) ? 15'd32767 : mag[14:0];
            r_neg[l] <= r_qn4[l] && (mag != 18'd0);
        end
    end

    // position products
    always_ff @(posedge i_clk) begin
        r_pxs <= r_mag[0] * r_mag[2];
        r_pzs <= r_mag[0] * r_mag[3];
        r_py  <= r_radius * r_mag[1];
        r_nx1 <= r_neg[0] ^ r_neg[2];
        r_nz1 <= r_neg[0] ^ r_neg[3];
        r_ny1 <= r_neg[1];

        r_px   <= r_radius * r_pxs;
        r_pz   <= r_radius * r_pzs;
        r_ymag <= 17'((r_py + 31'd16384) >> 15);
        r_nx2  <= r_nx1;
        r_nz2  <= r_nz1;
        r_ny2  <= r_ny1;
    end

    // output registers
    always_ff @(posedge i_clk) begin
        logic [16:0] xm, zm;
        xm = 17'((r_px + 46'd536870912) >> 30);
        zm = 17'((r_pz + 46'd536870912) >> 30);
        o_pos_x      <= r_nx2 ? 17'(17'd0 - xm) : xm;
        o_pos_z      <= r_nz2 ? 17'(17'd0 - zm) : zm;
        o_pos_y      <= r_ny2 ? 17'(17'd0 - r_ymag) : r_ymag;
        o_tex_u      <= r_side[7].tex_u;
        o_tex_v      <= r_side[7].tex_v;
        o_quad_valid <= r_side[7].quad_valid;
        o_corner_a   <= r_side[7].corner_a;
        o_corner_b   <= r_side[7].corner_b;
        o_corner_c   <= r_side[7].corner_c;
        o_corner_d   <= r_side[7].corner_a;
        o_corner_e   <= r_side[7].corner_c;
        o_corner_f   <= r_side[7].corner_f;
    end

    assign o_valid = r_vld[PIPE_LAST];

`ifndef SYNTHESIS
    a_no_quad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_quad_valid |-> o_corner_a == 16'd0 && o_corner_c == 16'd0
                                     && o_corner_f == 16'd0)
        else $error("corners not cleared without a quad");
    a_corner_f: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quad_valid |-> o_corner_f == 16'(o_corner_a + 16'd1)
                                    && o_corner_c == 16'(o_corner_b + 16'd1))
        else $error("corner indices inconsistent");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !r_vld[0])
        else $error("point taken while reciprocals are computed");
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tex_u <= 17'd65536 && o_tex_v <= 17'd65536)
        else $error("texture coordinate out of range");
`endif

endmodule : uv_sphere_mesh_point_top
`default_nettype wire
